// ===== src/mrtx_pkg.sv =====
package mrtx_pkg;

    // offset width and ring geometry
    localparam int OFF_W        = 17;
    localparam int BUFFER_BYTES = 131072;
    localparam int WORD_BYTES   = 4;
    localparam int WORD_MASK    = WORD_BYTES - 1;

    typedef logic [OFF_W-1:0] t_off;
    // one extra bit for sums and differences
    typedef logic [OFF_W:0]   t_off_x;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_CONN = 2'd2
    } t_status;

    typedef enum logic {
        CFG_RING_START = 1'b0,
        CFG_RING_END   = 1'b1
    } t_cfg_idx;

    // connection and write pointer state
    typedef struct packed {
        logic connected;
        t_off lat_start;
        t_off lat_end;
        t_off write_ptr;
    } t_ctx;

    // one descriptor result
    typedef struct packed {
        t_status status;
        t_off    header_addr;
        t_off    seg1_addr;
        t_off    seg1_len;
        t_off    seg2_addr;
        t_off    seg2_len;
        t_off    next_write;
    } t_res;

endpackage

// ===== src/mrtx_if.sv =====
// message request channel
interface mrtx_req_if import mrtx_pkg::*; ();
    logic valid;
    logic ready;
    t_off msg_len;
    t_off remote_read;

    modport source (output valid, output msg_len, output remote_read, input ready);
    modport sink   (input valid, input msg_len, input remote_read, output ready);
    modport mon    (input valid, input msg_len, input remote_read, input ready);
endinterface

// descriptor result channel
interface mrtx_res_if import mrtx_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_off    header_addr;
    t_off    seg1_addr;
    t_off    seg1_len;
    t_off    seg2_addr;
    t_off    seg2_len;
    t_off    next_write;

    modport source (
        output valid, output status, output header_addr, output seg1_addr,
        output seg1_len, output seg2_addr, output seg2_len, output next_write,
        input ready
    );
    modport sink (
        input valid, input status, input header_addr, input seg1_addr,
        input seg1_len, input seg2_addr, input seg2_len, input next_write,
        output ready
    );
    modport mon (
        input valid, input status, input header_addr, input seg1_addr,
        input seg1_len, input seg2_addr, input seg2_len, input next_write,
        input ready
    );
endinterface

// register write channel
interface mrtx_cfg_if import mrtx_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_off     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/mrtx_calc.sv =====
module mrtx_calc import mrtx_pkg::*; (
    input  t_off i_msg_len,
    input  t_off i_remote_read,
    input  t_off i_cfg_start,
    input  t_off i_cfg_end,
    input  t_ctx i_ctx,
    output t_res o_res,
    output t_ctx o_ctx
);

    function automatic t_off align_down(input t_off v);
        return v & ~t_off'(WORD_MASK);
    endfunction

    function automatic t_off_x round_up(input t_off_x v);
        return (v + t_off_x'(WORD_MASK)) & ~t_off_x'(WORD_MASK);
    endfunction

    logic             latch;
    t_ctx             cur;
    t_off_x           st;
    t_off_x           en;
    t_off_x           wr;
    t_off_x           rd;
    t_off_x           len_x;
    logic             bad_ring;
    t_off_x           free1;
    t_off_x           free2;
    t_off_x           need;
    logic [OFF_W+1:0] avail;
    logic             no_room;
    t_off_x           f1;
    t_off_x           s1len;
    t_off_x           s1addr;
    t_off_x           wr_a;
    t_off_x           rest;
    t_off_x           s2len;
    t_off_x           s2addr;
    t_off_x           wr_b;
    t_off_x           wr_n;

    // latch ring bounds on the first request once the partner offers a ring
    always_comb begin
        latch = !i_ctx.connected && (i_cfg_end != '0);
        cur   = i_ctx;
        if (latch) begin
            cur.connected = 1'b1;
            cur.lat_start = align_down(i_cfg_start);
            cur.lat_end   = align_down(i_cfg_end);
            cur.write_ptr = align_down(i_cfg_start);
        end
    end

    assign st    = {1'b0, cur.lat_start};
    assign en    = {1'b0, cur.lat_end};
    assign wr    = {1'b0, cur.write_ptr};
    assign rd    = {1'b0, align_down(i_remote_read)};
    assign len_x = {1'b0, i_msg_len};

    // ring sanity and read offset range
    assign bad_ring = (en <= st) || (en > t_off_x'(BUFFER_BYTES)) || (rd < st) || (rd >= en);

    // free space, one word always kept back
    always_comb begin
        priority if (rd > wr) begin
            free1 = rd - wr - t_off_x'(WORD_BYTES);
            free2 = '0;
        end else if (rd == st) begin
            free1 = en - wr - t_off_x'(WORD_BYTES);
            free2 = '0;
        end else begin
            free1 = en - wr;
            free2 = rd - st - t_off_x'(WORD_BYTES);
        end
    end

    assign need    = round_up(len_x + t_off_x'(WORD_BYTES));
    assign avail   = {1'b0, free1} + {1'b0, free2};
    assign no_room = {1'b0, need} > avail;

    // first segment up to the ring end
    assign f1     = free1 - t_off_x'(WORD_BYTES);
    assign s1len  = (f1 < len_x) ? f1 : len_x;
    assign s1addr = (s1len != '0) ? (wr + t_off_x'(WORD_BYTES)) : '0;
    assign wr_a   = wr + t_off_x'(WORD_BYTES) + round_up(s1len);
    assign rest   = len_x - s1len;

    // wrapped segment from the ring start
    assign s2len  = (rest == '0) ? '0 : ((free2 < rest) ? free2 : rest);
    assign s2addr = (rest == '0) ? '0 : st;
    assign wr_b   = (rest == '0) ? wr_a : (st + round_up(s2len));
    assign wr_n   = (wr_b == en) ? st : wr_b;

    // result and state update
    always_comb begin
        o_res = '0;
        o_ctx = cur;
        priority if (!cur.connected) begin
            o_res.status = ST_NOT_CONN;
        end else if (bad_ring || no_room) begin
            o_res.status     = ST_NO_SPACE;
            o_res.next_write = cur.write_ptr;
        end else begin
            o_res.status      = ST_OK;
            o_res.header_addr = cur.write_ptr;
            o_res.seg1_addr   = s1addr[OFF_W-1:0];
            o_res.seg1_len    = s1len[OFF_W-1:0];
            o_res.seg2_addr   = s2addr[OFF_W-1:0];
            o_res.seg2_len    = s2len[OFF_W-1:0];
            o_res.next_write  = wr_n[OFF_W-1:0];
            o_ctx.write_ptr   = wr_n[OFF_W-1:0];
        end
    end

endmodule

// ===== src/message_ring_tx_descriptor.sv =====
// Transmit descriptor engine for a shared-memory message ring.
// i_cfg writes ring_start (index 0) and ring_end (index 1) and is always
// ready; the user must write it only while the block is idle, which the
// block does not enforce. Bounds are taken at the first request that sees
// a nonzero ring_end and then held until reset. i_req carries one beat per
// message: payload length and the partner's read offset. o_res returns one
// beat per request: status, header offset, up to two payload segments and
// the new write offset. Throughput: one request per cycle while o_res is
// not stalled. A request accepted into the input register has its result
// moved into the output register once that register is empty or being
// read, which raises o_res.valid. The descriptor math sits in one stage
// between those two registers and the write pointer is updated when the
// output register loads, so back-to-back requests see each other's pointer.
// Reset (synchronous, active low) drops the connection, clears the write
// pointer, the registers and both pipeline stages.
// When the receiver stalls, the result holds; one more request is taken
// into the input register and then i_req.ready drops until o_res moves.
module message_ring_tx_descriptor import mrtx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mrtx_cfg_if.sink          i_cfg,
    mrtx_req_if.sink          i_req,
    mrtx_res_if.source        o_res
);

    t_off r_cfg_start;
    t_off r_cfg_end;
    t_ctx r_ctx;
    t_ctx n_ctx;
    logic r_in_valid;
    t_off r_msg_len;
    t_off r_remote_read;
    logic r_out_valid;
    t_res r_res;
    t_res n_res;
    logic advance;

    // pipeline flow control
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= '0;
            r_cfg_end   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_RING_START: r_cfg_start <= i_cfg.data;
                CFG_RING_END:   r_cfg_end   <= i_cfg.data;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_msg_len     <= i_req.msg_len;
            r_remote_read <= i_req.remote_read;
        end
    end

    mrtx_calc u_calc (
        .i_msg_len     (r_msg_len),
        .i_remote_read (r_remote_read),
        .i_cfg_start   (r_cfg_start),
        .i_cfg_end     (r_cfg_end),
        .i_ctx         (r_ctx),
        .o_res         (n_res),
        .o_ctx         (n_ctx)
    );

    // connection state and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '0;
        end else if (advance) begin
            r_ctx <= n_ctx;
        end
    end

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_res.status;
    assign o_res.header_addr = r_res.header_addr;
    assign o_res.seg1_addr   = r_res.seg1_addr;
    assign o_res.seg1_len    = r_res.seg1_len;
    assign o_res.seg2_addr   = r_res.seg2_addr;
    assign o_res.seg2_len    = r_res.seg2_len;
    assign o_res.next_write  = r_res.next_write;

endmodule

// ===== src/mrtx_chk.sv =====
module mrtx_chk import mrtx_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_res_valid,
    input logic    i_res_ready,
    input t_status i_res_status,
    input t_off    i_res_header_addr,
    input t_off    i_res_seg1_addr,
    input t_off    i_res_seg1_len,
    input t_off    i_res_seg2_addr,
    input t_off    i_res_seg2_len,
    input t_off    i_res_next_write
);

    // a not-connected answer carries nothing else
    a_not_conn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status == ST_NOT_CONN) |->
        (i_res_header_addr == '0 && i_res_seg1_addr == '0 && i_res_seg1_len == '0 &&
         i_res_seg2_addr == '0 && i_res_seg2_len == '0 && i_res_next_write == '0))
        else $error("not-connected beat with nonzero fields");

    // a rejected message carries only the write offset, which is word aligned
    a_no_space_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status == ST_NO_SPACE) |->
        (i_res_header_addr == '0 && i_res_seg1_addr == '0 && i_res_seg1_len == '0 &&
         i_res_seg2_addr == '0 && i_res_seg2_len == '0 && i_res_next_write[1:0] == '0))
        else $error("no-space beat with unexpected fields");

    // accepted messages land on word boundaries
    a_ok_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status == ST_OK) |->
        (i_res_header_addr[1:0] == '0 && i_res_next_write[1:0] == '0 &&
         i_res_seg1_addr[1:0] == '0 && i_res_seg2_addr[1:0] == '0))
        else $error("unaligned offset in accepted descriptor");

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        (i_res_valid && $stable(i_res_status) && $stable(i_res_header_addr) &&
         $stable(i_res_next_write) && $stable(i_res_seg1_len) && $stable(i_res_seg2_len)))
        else $error("result beat changed while stalled");

endmodule

bind message_ring_tx_descriptor mrtx_chk u_mrtx_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_status      (o_res.status),
    .i_res_header_addr (o_res.header_addr),
    .i_res_seg1_addr   (o_res.seg1_addr),
    .i_res_seg1_len    (o_res.seg1_len),
    .i_res_seg2_addr   (o_res.seg2_addr),
    .i_res_seg2_len    (o_res.seg2_len),
    .i_res_next_write  (o_res.next_write)
);
